// ===== rtl/rhd_pkg.sv =====
// rhd_pkg: shared types and constants of the rtp h264 depacketizer
// parse phases, queued emit commands, nal type codes
// no dependencies
package rhd_pkg;

    localparam int RHD_QUEUE_DEPTH = 4;

    localparam logic [4:0] NAL_TYPE_FIRST  = 5'd1;
    localparam logic [4:0] NAL_STAP_A      = 5'd24;
    localparam logic [4:0] NAL_FU_A        = 5'd28;
    localparam logic [4:0] NAL_FU_B        = 5'd29;
    localparam logic [7:0] NAL_NRI_MASK    = 8'hE0;
    localparam logic [7:0] NAL_TYPE_MASK   = 8'h1F;
    localparam int         FU_START_BIT    = 7;
    localparam logic [7:0] START_CODE_LAST = 8'h01;
    localparam logic [7:0] START_CODE_ZERO = 8'h00;

    localparam logic [17:0] FIXED_LAST_BYTE = 18'd11;
    localparam logic [17:0] STAMP_FIRST     = 18'd4;
    localparam logic [17:0] STAMP_LAST      = 18'd7;
    localparam logic [17:0] EXT_LEN_HIGH    = 18'd2;
    localparam logic [17:0] EXT_LEN_LOW     = 18'd3;
    localparam logic [17:0] DON_BYTES       = 18'd2;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_FIXED,
        PH_CSRC,
        PH_EXTH,
        PH_EXTB,
        PH_NALH,
        PH_COPY,
        PH_FUH,
        PH_DON,
        PH_STAPH,
        PH_STAPL,
        PH_STAPB
    } phase_t;

    typedef enum logic [1:0] {
        EMIT_BYTE,
        EMIT_START,
        EMIT_START_BYTE
    } emit_kind_t;

    typedef struct packed {
        emit_kind_t kind;
        logic [7:0] data;
        logic       au;
    } cmd_t;

endpackage

// ===== rtl/rhd_in_if.sv =====
// rhd_in_if: packet byte channel, valid/ready with first and last marks
// no dependencies
interface rhd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       pkt_first;
    logic       pkt_last;

    modport source (output valid, output data_byte, output pkt_first, output pkt_last,
                    input ready);
    modport sink   (input valid, input data_byte, input pkt_first, input pkt_last,
                    output ready);
endinterface

// ===== rtl/rhd_out_if.sv =====
// rhd_out_if: annex b stream byte channel, valid/ready
// no dependencies
interface rhd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       au_start;

    modport source (output valid, output out_byte, output run_last, output au_start,
                    input ready);
    modport sink   (input valid, input out_byte, input run_last, input au_start,
                    output ready);
endinterface

// ===== rtl/rhd_queue.sv =====
// rhd_queue: small command fifo between parser and emitter
// depends on rhd_pkg
module rhd_queue #(
    parameter int DEPTH = rhd_pkg::RHD_QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  rhd_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output rhd_pkg::cmd_t head_cmd
);
    import rhd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/rhd_parser.sv =====
// rhd_parser: takes packet beats, skips the rtp header, tracks timestamps
// and turns payload bytes into emit commands; depends on rhd_pkg, rhd_in_if
module rhd_parser (
    input  logic          clk,
    input  logic          rst_n,
    rhd_in_if.sink        pkt,
    input  logic          q_full,
    output logic          cmd_valid,
    output rhd_pkg::cmd_t cmd
);
    import rhd_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [17:0] hc_reg, hc_next;
    logic [3:0]  csrc_reg, csrc_next;
    logic        ext_flag_reg, ext_flag_next;
    logic [15:0] ext_words_reg, ext_words_next;
    logic [31:0] packet_stamp_reg, packet_stamp_next;
    logic [31:0] held_stamp_reg, held_stamp_next;
    logic        stamp_valid_reg, stamp_valid_next;
    logic        au_pending_reg, au_pending_next;
    logic [7:0]  fu_ind_reg, fu_ind_next;
    logic [15:0] stap_rem_reg, stap_rem_next;
    logic [7:0]  stap_high_reg, stap_high_next;

    logic        accept;
    phase_t      phase_cur;
    logic [17:0] hc_cur, hc_dec;
    logic [31:0] stamp_shift;
    logic [15:0] ext_len, stap_len, stap_dec;
    logic [4:0]  nal_type;
    logic [7:0]  b;

    assign pkt.ready   = !q_full;
    assign accept      = pkt.valid && !q_full;
    assign b           = pkt.data_byte;
    assign phase_cur   = pkt.pkt_first ? PH_FIXED : phase_reg;
    assign hc_cur      = pkt.pkt_first ? '0 : hc_reg;
    assign hc_dec      = (hc_cur != '0) ? hc_cur - 18'd1 : hc_cur;
    assign stamp_shift = {packet_stamp_reg[23:0], b};
    assign ext_len     = {ext_words_reg[15:8], b};
    assign stap_len    = {stap_high_reg, b};
    assign stap_dec    = (stap_rem_reg != '0) ? stap_rem_reg - 16'd1 : stap_rem_reg;
    assign nal_type    = b[4:0];

    always_comb
    begin
        cmd_valid = 1'b0;
        cmd.kind  = EMIT_BYTE;
        cmd.data  = b;
        cmd.au    = au_pending_reg;
        if (accept)
        begin
            case (phase_cur)
                PH_NALH:
                begin
                    if (nal_type >= NAL_TYPE_FIRST && nal_type < NAL_STAP_A)
                    begin
                        cmd_valid = 1'b1;
                        cmd.kind  = EMIT_START_BYTE;
                    end
                    else if (nal_type != NAL_STAP_A && nal_type != NAL_FU_A &&
                             nal_type != NAL_FU_B)
                    begin
                        cmd_valid = 1'b1;
                    end
                end
                PH_FUH:
                begin
                    if (b[FU_START_BIT])
                    begin
                        cmd_valid = 1'b1;
                        cmd.kind  = EMIT_START_BYTE;
                        cmd.data  = (fu_ind_reg & NAL_NRI_MASK) | (b & NAL_TYPE_MASK);
                    end
                end
                PH_COPY:
                begin
                    cmd_valid = 1'b1;
                end
                PH_STAPL:
                begin
                    cmd_valid = 1'b1;
                    cmd.kind  = EMIT_START;
                end
                PH_STAPB:
                begin
                    cmd_valid = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        phase_next        = phase_reg;
        hc_next           = hc_reg;
        csrc_next         = csrc_reg;
        ext_flag_next     = ext_flag_reg;
        ext_words_next    = ext_words_reg;
        packet_stamp_next = packet_stamp_reg;
        held_stamp_next   = held_stamp_reg;
        stamp_valid_next  = stamp_valid_reg;
        au_pending_next   = au_pending_reg;
        fu_ind_next       = fu_ind_reg;
        stap_rem_next     = stap_rem_reg;
        stap_high_next    = stap_high_reg;

        if (accept)
        begin
            if (pkt.pkt_first)
            begin
                phase_next        = PH_FIXED;
                hc_next           = '0;
                packet_stamp_next = '0;
            end

            case (phase_cur)
                PH_FIXED:
                begin
                    if (hc_cur == '0)
                    begin
                        ext_flag_next = b[4];
                        csrc_next     = b[3:0];
                    end
                    if (hc_cur >= STAMP_FIRST && hc_cur <= STAMP_LAST)
                    begin
                        packet_stamp_next = stamp_shift;
                    end
                    if (hc_cur == STAMP_LAST)
                    begin
                        if (!stamp_valid_reg || stamp_shift > held_stamp_reg)
                        begin
                            held_stamp_next  = stamp_shift;
                            stamp_valid_next = 1'b1;
                            au_pending_next  = 1'b1;
                        end
                    end
                    if (hc_cur >= FIXED_LAST_BYTE)
                    begin
                        if (csrc_reg != '0)
                        begin
                            hc_next    = {12'd0, csrc_reg, 2'b00};
                            phase_next = PH_CSRC;
                        end
                        else
                        begin
                            hc_next    = '0;
                            phase_next = ext_flag_reg ? PH_EXTH : PH_NALH;
                        end
                    end
                    else
                    begin
                        hc_next = hc_cur + 18'd1;
                    end
                end
                PH_CSRC:
                begin
                    hc_next = hc_dec;
                    if (hc_dec == '0)
                    begin
                        phase_next = ext_flag_reg ? PH_EXTH : PH_NALH;
                    end
                end
                PH_EXTH:
                begin
                    if (hc_cur == EXT_LEN_HIGH)
                    begin
                        ext_words_next = {b, 8'h00};
                    end
                    if (hc_cur == EXT_LEN_LOW)
                    begin
                        ext_words_next = ext_len;
                        if (ext_len != '0)
                        begin
                            hc_next    = {ext_len, 2'b00};
                            phase_next = PH_EXTB;
                        end
                        else
                        begin
                            hc_next    = '0;
                            phase_next = PH_NALH;
                        end
                    end
                    else
                    begin
                        hc_next = hc_cur + 18'd1;
                    end
                end
                PH_EXTB:
                begin
                    hc_next = hc_dec;
                    if (hc_dec == '0)
                    begin
                        phase_next = PH_NALH;
                    end
                end
                PH_NALH:
                begin
                    if (nal_type >= NAL_TYPE_FIRST && nal_type < NAL_STAP_A)
                    begin
                        phase_next = PH_COPY;
                    end
                    else if (nal_type == NAL_STAP_A)
                    begin
                        phase_next = PH_STAPH;
                    end
                    else if (nal_type == NAL_FU_A || nal_type == NAL_FU_B)
                    begin
                        fu_ind_next = b;
                        phase_next  = PH_FUH;
                    end
                    else
                    begin
                        phase_next = PH_COPY;
                    end
                end
                PH_FUH:
                begin
                    if (fu_ind_reg[4:0] == NAL_FU_B)
                    begin
                        hc_next    = DON_BYTES;
                        phase_next = PH_DON;
                    end
                    else
                    begin
                        phase_next = PH_COPY;
                    end
                end
                PH_DON:
                begin
                    hc_next = hc_dec;
                    if (hc_dec == '0)
                    begin
                        phase_next = PH_COPY;
                    end
                end
                PH_STAPH:
                begin
                    stap_high_next = b;
                    phase_next     = PH_STAPL;
                end
                PH_STAPL:
                begin
                    stap_rem_next = stap_len;
                    phase_next    = (stap_len == '0) ? PH_STAPH : PH_STAPB;
                end
                PH_STAPB:
                begin
                    stap_rem_next = stap_dec;
                    if (stap_dec == '0)
                    begin
                        phase_next = PH_STAPH;
                    end
                end
                default:
                begin
                end
            endcase

            if (pkt.pkt_last)
            begin
                phase_next = PH_IDLE;
            end
            if (cmd_valid)
            begin
                au_pending_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            hc_reg           <= '0;
            csrc_reg         <= '0;
            ext_flag_reg     <= 1'b0;
            ext_words_reg    <= '0;
            packet_stamp_reg <= '0;
            held_stamp_reg   <= '0;
            stamp_valid_reg  <= 1'b0;
            au_pending_reg   <= 1'b0;
            fu_ind_reg       <= '0;
            stap_rem_reg     <= '0;
            stap_high_reg    <= '0;
        end
        else
        begin
            phase_reg        <= phase_next;
            hc_reg           <= hc_next;
            csrc_reg         <= csrc_next;
            ext_flag_reg     <= ext_flag_next;
            ext_words_reg    <= ext_words_next;
            packet_stamp_reg <= packet_stamp_next;
            held_stamp_reg   <= held_stamp_next;
            stamp_valid_reg  <= stamp_valid_next;
            au_pending_reg   <= au_pending_next;
            fu_ind_reg       <= fu_ind_next;
            stap_rem_reg     <= stap_rem_next;
            stap_high_reg    <= stap_high_next;
        end
    end

endmodule

// ===== rtl/rhd_emitter.sv =====
// rhd_emitter: expands queued commands into stream beats behind an output register
// depends on rhd_pkg, rhd_out_if
module rhd_emitter (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    input  rhd_pkg::cmd_t head_cmd,
    output logic          pop,
    rhd_out_if.source     stream
);
    import rhd_pkg::*;

    logic [1:0] step_reg, step_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       last_reg, last_next;
    logic       au_reg, au_next;

    logic       load;
    logic [1:0] last_step;
    logic [7:0] beat_byte;

    assign stream.valid    = valid_reg;
    assign stream.out_byte = byte_reg;
    assign stream.run_last = last_reg;
    assign stream.au_start = au_reg;

    assign load = head_valid && (!valid_reg || stream.ready);
    assign pop  = load && (step_reg == last_step);

    always_comb
    begin
        case (head_cmd.kind)
            EMIT_BYTE:
            begin
                last_step = 2'd0;
                beat_byte = head_cmd.data;
            end
            EMIT_START:
            begin
                last_step = 2'd2;
                beat_byte = (step_reg == 2'd2) ? START_CODE_LAST : START_CODE_ZERO;
            end
            EMIT_START_BYTE:
            begin
                last_step = 2'd3;
                case (step_reg)
                    2'd2:    beat_byte = START_CODE_LAST;
                    2'd3:    beat_byte = head_cmd.data;
                    default: beat_byte = START_CODE_ZERO;
                endcase
            end
            default:
            begin
                last_step = 2'd0;
                beat_byte = head_cmd.data;
            end
        endcase
    end

    always_comb
    begin
        step_next  = step_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        au_next    = au_reg;
        if (load)
        begin
            valid_next = 1'b1;
            byte_next  = beat_byte;
            last_next  = (step_reg == last_step);
            au_next    = head_cmd.au && (step_reg == 2'd0);
            step_next  = pop ? 2'd0 : step_reg + 2'd1;
        end
        else if (stream.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
        au_reg   <= au_next;
    end

endmodule

// ===== rtl/rtp_h264_depacketizer.sv =====
// rtp_h264_depacketizer: rtp packet bytes in, annex b h264 byte stream out
// an accepted beat's command passes the queue, then the emitter output register
// throughput: one packet beat per cycle; a start-coded nal header costs 3 or 4
// stream beats from the emitter, so input stalls once the command queue fills
// reset: rst_n asynchronous active low, clears parser phase, timestamps and queue
// depends on rhd_pkg, rhd_in_if, rhd_out_if, rhd_parser, rhd_queue, rhd_emitter
module rtp_h264_depacketizer #(
    parameter int QUEUE_DEPTH = rhd_pkg::RHD_QUEUE_DEPTH
) (
    input  logic      clk,
    input  logic      rst_n,
    rhd_in_if.sink    pkt,
    rhd_out_if.source stream
);
    import rhd_pkg::*;

    logic q_full;
    logic cmd_valid;
    cmd_t cmd;
    logic head_valid;
    cmd_t head_cmd;
    logic pop;

    rhd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt       (pkt),
        .q_full    (q_full),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    rhd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (cmd_valid),
        .push_cmd   (cmd),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    rhd_emitter u_emitter (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .stream     (stream)
    );

endmodule
